// ----- rtl/mpsq_pkg.sv -----
// Package for the masked pending signal queue: sizes, result codes and item types.
`default_nettype none

package mpsq_pkg;

    // Queue sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SIG_W       = 4;
    localparam int MASK_W      = 16;

    // Request codes
    localparam logic REQ_POST    = 1'b0;
    localparam logic REQ_PROCESS = 1'b1;

    // Result codes
    typedef enum logic [1:0] {
        KIND_ACCEPT  = 2'd0,
        KIND_FULL    = 2'd1,
        KIND_DELIVER = 2'd2,
        KIND_DONE    = 2'd3
    } kind_t;

    typedef struct packed {
        logic              req_type;
        logic [SIG_W-1:0]  signal_id;
        logic [MASK_W-1:0] thread_block_mask;
        logic [MASK_W-1:0] handler_present_mask;
    } in_item_t;

    typedef struct packed {
        kind_t             result_kind;
        logic [SIG_W-1:0]  delivered_id;
        logic              call_handler;
        logic              last;
    } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/mpsq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mpsq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/masked_pending_signal_queue_unit.sv -----
// Masked pending signal queue: ordered signal queue with post and masked delivery walk.
//
// Input channel in_valid/in_ready/in_item carries post or process requests;
// output channel out_valid/out_ready/out_item returns results, one register deep.
// The global block mask is written through cfg_wr_en/cfg_wr_data, taken at once.
// A post gives one result (accepted or full) in the cycle after acceptance.
// A process walks the queue oldest first, one entry per cycle out of the queue
// RAM while the output slot is free (blocked entries do not wait for it), and
// gives one delivered result per unblocked entry followed by a walk-done result
// with last set. Blocked entries are written back in order at the compacted position.
// One item is handled at a time; in_ready is low during a walk.
// When the receiver stalls, the walk pauses on the entry waiting to be delivered.
// Reset empties the queue and clears the global mask; no RAM clearing pass is
// needed since only entries below the count are ever read.
`default_nettype none

module masked_pending_signal_queue_unit
    import mpsq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_item,
    input  wire logic              cfg_wr_en,
    input  wire logic [MASK_W-1:0] cfg_wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  keep_reg, keep_next;
    logic [MASK_W-1:0] gmask_reg, gmask_next;
    logic [MASK_W-1:0] blocked_reg, blocked_next;
    logic [MASK_W-1:0] hmask_reg, hmask_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [SIG_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [SIG_W-1:0]  ram_rdata;

    logic              slot_free;
    logic              in_fire;
    logic              entry_blocked;
    logic              advance;
    logic              at_end;
    logic [CNT_W-1:0]  idx_inc;

    // Queue storage
    mpsq_ram #(
        .WIDTH (SIG_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake and walk status
    assign slot_free     = !out_valid_reg || out_ready;
    assign in_ready      = (state_reg == ST_IDLE) && slot_free;
    assign in_fire       = in_valid && in_ready;
    assign entry_blocked = blocked_reg[ram_rdata];
    assign advance       = (state_reg == ST_WALK) && (entry_blocked || slot_free);
    assign idx_inc       = idx_reg + CNT_W'(1);
    assign at_end        = (idx_inc == cnt_reg);
    assign out_valid     = out_valid_reg;
    assign out_item      = out_item_reg;

    // Read the next entry as soon as the current one is retired
    always_comb
    begin
        if (advance && !at_end)
        begin
            ram_raddr = idx_inc[IDX_W-1:0];
        end
        else
        begin
            ram_raddr = idx_reg[IDX_W-1:0];
        end
    end

    // Next-state and datapath
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        keep_next      = keep_reg;
        gmask_next     = gmask_reg;
        blocked_next   = blocked_reg;
        hmask_next     = hmask_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[IDX_W-1:0];
        ram_wdata      = in_item.signal_id;

        if (cfg_wr_en)
        begin
            gmask_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_item.req_type == REQ_POST)
                    begin
                        out_valid_next             = 1'b1;
                        out_item_next.delivered_id = '0;
                        out_item_next.call_handler = 1'b0;
                        out_item_next.last         = 1'b1;
                        if (cnt_reg >= CNT_W'(QUEUE_DEPTH))
                        begin
                            out_item_next.result_kind = KIND_FULL;
                        end
                        else
                        begin
                            out_item_next.result_kind = KIND_ACCEPT;
                            ram_we                    = 1'b1;
                            cnt_next                  = cnt_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        blocked_next = gmask_reg | in_item.thread_block_mask;
                        hmask_next   = in_item.handler_present_mask;
                        idx_next     = '0;
                        keep_next    = '0;
                        state_next   = (cnt_reg == '0) ? ST_DONE : ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                if (advance)
                begin
                    if (entry_blocked)
                    begin
                        // Keep in place order; skip a write onto itself
                        ram_we    = (keep_reg != idx_reg);
                        ram_waddr = keep_reg[IDX_W-1:0];
                        ram_wdata = ram_rdata;
                        keep_next = keep_reg + CNT_W'(1);
                    end
                    else
                    begin
                        out_valid_next             = 1'b1;
                        out_item_next.result_kind  = KIND_DELIVER;
                        out_item_next.delivered_id = ram_rdata;
                        out_item_next.call_handler = hmask_reg[ram_rdata];
                        out_item_next.last         = 1'b0;
                    end
                    idx_next = idx_inc;
                    if (at_end)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.result_kind  = KIND_DONE;
                    out_item_next.delivered_id = '0;
                    out_item_next.call_handler = 1'b0;
                    out_item_next.last         = 1'b1;
                    cnt_next                   = keep_reg;
                    // Idle reads the oldest entry, ready for the next walk
                    idx_next                   = '0;
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            keep_reg      <= '0;
            gmask_reg     <= '0;
            blocked_reg   <= '0;
            hmask_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            keep_reg      <= keep_next;
            gmask_reg     <= gmask_next;
            blocked_reg   <= blocked_next;
            hmask_reg     <= hmask_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_keep_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (keep_reg <= idx_reg))
        else $error("compaction pointer ahead of walk");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == ST_WALK) |-> (ram_waddr != ram_raddr))
        else $error("write back collides with read address");

    a_deliver_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.result_kind == KIND_DELIVER) |-> !out_item_reg.last)
        else $error("delivered item marked last");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (idx_reg < cnt_reg))
        else $error("walk index past queue count");

endmodule

`default_nettype wire

// ----- bench/masked_pending_signal_queue_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the masked pending signal queue: directed and random posts and walks.
module masked_pending_signal_queue_unit_tb;
    import mpsq_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 32;
    localparam int SETTLE      = 24;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    in_item_t          in_item     = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    out_item_t         out_item;
    logic              cfg_wr_en   = 1'b0;
    logic [MASK_W-1:0] cfg_wr_data = '0;

    // Bench copy of the queue contents and the global mask
    logic [SIG_W-1:0]  pending_sigs[$];
    logic [MASK_W-1:0] global_mask_copy = '0;

    // Results still owed by the block, oldest first
    out_item_t         awaited_results[$];
    // Items waiting to be offered on the input channel
    in_item_t          stimulus_fifo[$];

    int issued_count   = 0;
    int accepted_count = 0;
    int src_wait       = 0;
    int sink_wait      = 0;
    int src_gap_max    = 0;
    int sink_gap_max   = 0;
    int hold_req       = 0;
    int hold_taken     = 0;
    bit mismatch_seen  = 1'b0;

    masked_pending_signal_queue_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the results of one accepted item and update the queue copy
    function automatic void forecast_results(input in_item_t req);
        logic [SIG_W-1:0]  kept[$];
        logic [MASK_W-1:0] blocked;
        out_item_t         res;
        res = '0;
        if (req.req_type == REQ_POST)
        begin
            res.last = 1'b1;
            if (pending_sigs.size() >= QUEUE_DEPTH)
                res.result_kind = KIND_FULL;
            else
            begin
                pending_sigs.push_back(req.signal_id);
                res.result_kind = KIND_ACCEPT;
            end
            awaited_results.push_back(res);
        end
        else
        begin
            blocked = global_mask_copy | req.thread_block_mask;
            foreach (pending_sigs[i])
            begin
                if (blocked[pending_sigs[i]])
                    kept.push_back(pending_sigs[i]);
                else
                begin
                    res.result_kind  = KIND_DELIVER;
                    res.delivered_id = pending_sigs[i];
                    res.call_handler = req.handler_present_mask[pending_sigs[i]];
                    res.last         = 1'b0;
                    awaited_results.push_back(res);
                end
            end
            pending_sigs = kept;
            res = '0;
            res.result_kind = KIND_DONE;
            res.last        = 1'b1;
            awaited_results.push_back(res);
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_seen = 1'b1;
        end
    endfunction

    task automatic issue_item(input logic rt, input int sid, input int tm, input int hm);
        in_item_t req;
        req.req_type             = rt;
        req.signal_id            = sid[SIG_W-1:0];
        req.thread_block_mask    = tm[MASK_W-1:0];
        req.handler_present_mask = hm[MASK_W-1:0];
        stimulus_fifo.push_back(req);
        issued_count++;
    endtask

    // Wait until every item is taken and every result has come back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (accepted_count != issued_count || awaited_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_global_mask(input logic [MASK_W-1:0] value);
        @(posedge clk);
        cfg_wr_en        <= 1'b1;
        cfg_wr_data      <= value;
        global_mask_copy  = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Input side: offer queued items, random gap drawn after each acceptance
    always @(posedge clk or negedge rst_n)
    begin : feed
        logic next_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
            src_wait  = 0;
        end
        else
        begin
            next_valid = in_valid;
            if (in_valid && in_ready)
            begin
                forecast_results(in_item);
                accepted_count++;
                next_valid = 1'b0;
                src_wait   = $urandom_range(0, src_gap_max);
            end
            if (!next_valid)
            begin
                if (src_wait > 0)
                    src_wait--;
                else if (stimulus_fifo.size() > 0)
                begin
                    in_item   <= stimulus_fifo.pop_front();
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    // Output side: check each result, random stall per result, long hold on request
    always @(posedge clk or negedge rst_n)
    begin : observe
        out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_wait  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d id %0d call %0d last %0d",
                           out_item.result_kind, out_item.delivered_id,
                           out_item.call_handler, out_item.last);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("result_kind", want.result_kind, out_item.result_kind);
                    check_field("delivered_id", want.delivered_id, out_item.delivered_id);
                    check_field("call_handler", want.call_handler, out_item.call_handler);
                    check_field("last", want.last, out_item.last);
                end
                sink_wait = $urandom_range(0, sink_gap_max);
            end
            if (hold_req != hold_taken)
            begin
                hold_taken = hold_req;
                sink_wait  = HOLD_CYCLES;
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        logic [MASK_W-1:0] phase_masks[NUM_PHASES];
        int                src_gaps[NUM_PHASES];
        int                sink_gaps[NUM_PHASES];
        int                post_pct[NUM_PHASES];
        logic              rt;
        int                tm;

        phase_masks = '{16'hFFFF, 16'h0000, 16'h0000, 16'h8001, 16'h0000, 16'h0000};
        phase_masks[2] = $urandom_range(0, 16'hFFFF);
        phase_masks[4] = $urandom_range(0, 16'hFFFF);
        phase_masks[5] = $urandom_range(0, 16'hFFFF);
        src_gaps    = '{12, 0, 12, 0, 12, 4};
        sink_gaps   = '{12, 12, 0, 0, 5, 12};
        post_pct    = '{60, 80, 50, 90, 70, 75};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty walk, fill every id, full queue, masked walks, sole entry
        src_gap_max  = 3;
        sink_gap_max = 3;
        issue_item(REQ_PROCESS, 0, 0, 16'hFFFF);
        for (int s = 0; s < 16; s++)
            issue_item(REQ_POST, s, (s % 2) ? 16'hFFFF : 0, s * 16'h1111);
        issue_item(REQ_POST, 15, 0, 0);
        issue_item(REQ_PROCESS, 0, 16'hFFFF, 16'hFFFF);
        issue_item(REQ_PROCESS, 15, 16'hAAAA, 16'h5555);
        issue_item(REQ_PROCESS, 0, 0, 0);
        issue_item(REQ_POST, 7, 0, 0);
        issue_item(REQ_PROCESS, 0, 0, 16'h0080);
        issue_item(REQ_PROCESS, 0, 0, 0);
        wait_drained();

        // Random phases, one global mask setting each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_global_mask(phase_masks[p]);
            src_gap_max  = src_gaps[p];
            sink_gap_max = sink_gaps[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                rt = ($urandom_range(0, 99) < post_pct[p]) ? REQ_POST : REQ_PROCESS;
                case ($urandom_range(0, 3))
                    0:       tm = 0;
                    1:       tm = 16'hFFFF;
                    2:       tm = 1 << $urandom_range(0, 15);
                    default: tm = $urandom_range(0, 16'hFFFF);
                endcase
                issue_item(rt, $urandom_range(0, 15), tm, $urandom_range(0, 16'hFFFF));
            end
            // receiver holds off while the sender keeps offering
            if (p == 1)
                hold_req++;
            wait_drained();
        end

        if (!mismatch_seen && awaited_results.size() == 0)
            $display("masked_pending_signal_queue_unit verification clean");
        else
            $display("masked_pending_signal_queue_unit verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("masked_pending_signal_queue_unit verification failed");
        $finish;
    end

endmodule
